// ----- rtl/tvhc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TTL verdict hash cache package
// Shared constants, types and time compare helpers.
// ----------------------------------------------------------------------------
package tvhc_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int PROBE_LENGTH_DEF  = 8;
    localparam int ADDR_W            = 3;

    localparam logic [ADDR_W-1:0] REG_ENABLE = 3'd0;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [31:0] route;
        logic [15:0] phase_opcode;
    } t_slot_key;

    // signed(a - b) <= 0
    function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d == 32'd0) || d[31];
    endfunction

    // signed(a - b) < 0
    function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ttl_verdict_hash_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Steps: a read and an evaluate state per probed slot, a write state to write back an
//   insert and a done state to post the result; a beat taken while disabled, or an insert
//   with zero ttl, goes straight to the done state. A new beat is taken only once the last
//   result is posted; a stalled result holds the input.
// Reset: synchronous; a clearing pass over every slot zeroes the expiry
//   memory while input is stalled. Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// TTL verdict hash cache
// Linear-probe hash table of verdicts with expiry, held in two slot memories.
// ----------------------------------------------------------------------------
module ttl_verdict_hash_cache
    import tvhc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PROBE_LENGTH  = PROBE_LENGTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_command,
    input  wire logic [63:0]       i_key_hi,
    input  wire logic [63:0]       i_key_lo,
    input  wire logic [31:0]       i_route,
    input  wire logic [7:0]        i_phase,
    input  wire logic [7:0]        i_opcode,
    input  wire logic [31:0]       i_ttl_ms,
    input  wire logic [31:0]       i_now_ms,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_hit,
    output logic [31:0]            o_hit_count,
    output logic [31:0]            o_miss_count,
    output logic [31:0]            o_insert_count
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(PROBE_LENGTH + 1);
    localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LENGTH - 1);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state        r_state;
    logic          r_enable;
    logic [IW-1:0] r_clr_idx;

    logic          r_cmd;
    logic          r_act;
    t_slot_key     r_key;
    logic [31:0]   r_ttl;
    logic [31:0]   r_now;
    logic [IW-1:0] r_slot;
    logic [PW-1:0] r_probe;
    logic          r_hit;
    logic          r_have_empty;
    logic [IW-1:0] r_empty;
    logic          r_have_soon;
    logic [IW-1:0] r_soon;
    logic [31:0]   r_soon_exp;
    logic [IW-1:0] r_victim;

    logic [31:0]   r_hits;
    logic [31:0]   r_misses;
    logic [31:0]   r_inserts;

    t_slot_key     key_mem [TABLE_ENTRIES];
    logic [31:0]   exp_mem [TABLE_ENTRIES];
    t_slot_key     r_rd_key;
    logic [31:0]   r_rd_exp;

    logic          w_exp_we;
    logic [IW-1:0] w_exp_addr;
    logic [31:0]   w_exp_data;
    logic          w_key_we;

    logic          w_match;
    logic          w_stale;
    logic          w_last;
    logic          n_have_empty;
    logic [IW-1:0] n_empty;
    logic          n_have_soon;
    logic [IW-1:0] n_soon;
    logic [31:0]   n_soon_exp;
    logic          w_accept;
    logic          w_load;

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_ENABLE) ? {31'd0, r_enable} : 32'd0;
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_DONE) && (!o_valid || !i_stall);

    assign w_match = (r_rd_exp != 32'd0) && (r_rd_key == r_key);
    assign w_stale = not_after(r_rd_exp, r_now);
    assign w_last  = (r_probe == LAST_PROBE);

    always_comb begin
        n_have_empty = r_have_empty;
        n_empty      = r_empty;
        n_have_soon  = r_have_soon;
        n_soon       = r_soon;
        n_soon_exp   = r_soon_exp;
        if ((r_rd_exp == 32'd0) || w_stale) begin
            if (!r_have_empty) begin
                n_have_empty = 1'b1;
                n_empty      = r_slot;
            end
        end else if (!r_have_soon || is_before(r_rd_exp, r_soon_exp)) begin
            n_have_soon = 1'b1;
            n_soon      = r_slot;
            n_soon_exp  = r_rd_exp;
        end
    end

    always_comb begin
        w_exp_we   = 1'b0;
        w_exp_addr = r_slot;
        w_exp_data = 32'd0;
        w_key_we   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_exp_we   = 1'b1;
                w_exp_addr = r_clr_idx;
            end
            S_EVAL: begin
                if (r_cmd == CMD_LOOKUP && w_match && w_stale) begin
                    w_exp_we = 1'b1;
                end
            end
            S_WRITE: begin
                w_exp_we   = 1'b1;
                w_exp_addr = r_victim;
                w_exp_data = r_now + r_ttl;
                w_key_we   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_exp_we) begin
            exp_mem[w_exp_addr] <= w_exp_data;
        end
        if (w_key_we) begin
            key_mem[r_victim] <= r_key;
        end
        r_rd_exp <= exp_mem[r_slot];
        r_rd_key <= key_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == REG_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_hits    <= 32'd0;
            r_misses  <= 32'd0;
            r_inserts <= 32'd0;
            o_valid   <= 1'b0;
        end else begin
            if (o_valid && !i_stall && !w_load) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd          <= i_command;
                        r_act          <= r_enable && (i_command == CMD_LOOKUP ||
                                                       i_ttl_ms != 32'd0);
                        r_key          <= '{i_key_hi, i_key_lo, i_route, {i_phase, i_opcode}};
                        r_ttl          <= i_ttl_ms;
                        r_now          <= i_now_ms;
                        r_slot         <= i_key_hi[IW-1:0];
                        r_probe        <= '0;
                        r_hit          <= 1'b0;
                        r_have_empty   <= 1'b0;
                        r_have_soon    <= 1'b0;
                        r_state        <= (r_enable && (i_command == CMD_LOOKUP ||
                                           i_ttl_ms != 32'd0)) ? S_READ : S_DONE;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_slot  <= r_slot + 1'b1;
                    r_probe <= r_probe + 1'b1;
                    if (r_cmd == CMD_LOOKUP) begin
                        if (w_match && !w_stale) begin
                            r_hit   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= w_last ? S_DONE : S_READ;
                        end
                    end else begin
                        r_have_empty <= n_have_empty;
                        r_empty      <= n_empty;
                        r_have_soon  <= n_have_soon;
                        r_soon       <= n_soon;
                        r_soon_exp   <= n_soon_exp;
                        if (w_match) begin
                            r_victim <= r_slot;
                            r_state  <= S_WRITE;
                        end else if (w_last) begin
                            r_victim <= n_have_empty ? n_empty : n_soon;
                            r_state  <= S_WRITE;
                        end else begin
                            r_state  <= S_READ;
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        o_valid        <= 1'b1;
                        o_hit          <= r_hit;
                        if (r_act && r_cmd == CMD_LOOKUP && r_hit) begin
                            r_hits      <= r_hits + 32'd1;
                            o_hit_count <= r_hits + 32'd1;
                        end else begin
                            o_hit_count <= r_hits;
                        end
                        if (r_act && r_cmd == CMD_LOOKUP && !r_hit) begin
                            r_misses     <= r_misses + 32'd1;
                            o_miss_count <= r_misses + 32'd1;
                        end else begin
                            o_miss_count <= r_misses;
                        end
                        if (r_act && r_cmd == CMD_INSERT) begin
                            r_inserts      <= r_inserts + 32'd1;
                            o_insert_count <= r_inserts + 32'd1;
                        end else begin
                            o_insert_count <= r_inserts;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_stall)
        else $error("input taken during clearing pass");

    a_insert_no_probe_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_cmd == CMD_INSERT) |-> !w_exp_we)
        else $error("expiry written while probing for insert");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_READ || r_state == S_DONE))
        else $error("accepted beat did not start");

    a_hit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_hit) |=> (r_hits == $past(r_hits) + 32'd1))
        else $error("hit not counted");

endmodule
`default_nettype wire

// ----- bench/ttl_verdict_hash_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TTL verdict hash cache testbench
// Drives lookups and inserts through the valid/stall input channel, predicts
// hit flag and counters with a behavioural copy of the probed table, and
// checks every result beat in order. Covers enable toggling, expiry, victim
// choice, wrapping times and random stalls on both channels.
// ----------------------------------------------------------------------------
module ttl_verdict_hash_cache_tb;
    import tvhc_pkg::*;

    localparam int N_SLOTS = TABLE_ENTRIES_DEF;
    localparam int WINDOW  = PROBE_LENGTH_DEF;
    localparam int LIMIT   = 2_000_000;

    typedef struct packed {
        logic        command;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [31:0] route;
        logic [7:0]  phase;
        logic [7:0]  opcode;
        logic [31:0] ttl_ms;
        logic [31:0] now_ms;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] insert_count;
    } t_verdict;

    typedef struct {
        t_req     req;
        logic     known;
        t_verdict res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    t_req              req_q;
    logic              o_valid;
    logic              i_stall;
    logic              o_hit;
    logic [31:0]       o_hit_count, o_miss_count, o_insert_count;

    ttl_verdict_hash_cache u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(req_q.command), .i_key_hi(req_q.key_hi), .i_key_lo(req_q.key_lo),
        .i_route(req_q.route), .i_phase(req_q.phase), .i_opcode(req_q.opcode),
        .i_ttl_ms(req_q.ttl_ms), .i_now_ms(req_q.now_ms),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit),
        .o_hit_count(o_hit_count), .o_miss_count(o_miss_count),
        .o_insert_count(o_insert_count)
    );

    // predictor state
    t_slot_key   tbl_key [N_SLOTS];
    logic [31:0] tbl_exp [N_SLOTS];
    logic [31:0] n_hits, n_misses, n_inserts;
    logic        cache_on;

    t_verdict verdicts_due[$];
    int       errors;
    int       results_seen;
    int       hits_seen;
    int       cycles;
    int       send_idle_pct, recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("[ttl_verdict_hash_cache] ERROR");
                $finish;
            end
        end
    end

    function automatic logic lapsed(logic [31:0] e, logic [31:0] now);
        logic [31:0] d;
        d = e - now;
        return (d == 32'd0) || d[31];
    endfunction

    function automatic t_verdict predict_verdict(t_req r);
        t_verdict   v;
        t_slot_key  k;
        int         s, victim, empty_s, soon_s;
        logic       found, got_empty, got_soon;
        logic [31:0] dd;
        k = '{r.key_hi, r.key_lo, r.route, {r.phase, r.opcode}};
        v.hit = 1'b0;
        found = 0; got_empty = 0; got_soon = 0;
        victim = 0; empty_s = 0; soon_s = 0;
        if (r.command == CMD_LOOKUP) begin
            if (cache_on) begin
                for (int i = 0; i < WINDOW; i++) begin
                    s = (r.key_hi[11:0] + i) % N_SLOTS;
                    if (tbl_exp[s] == 0 || tbl_key[s] != k) continue;
                    if (lapsed(tbl_exp[s], r.now_ms)) begin
                        tbl_exp[s] = 0;
                        continue;
                    end
                    v.hit = 1'b1;
                    break;
                end
                if (v.hit) n_hits++;
                else n_misses++;
            end
        end else if (cache_on && r.ttl_ms != 0) begin
            for (int i = 0; i < WINDOW; i++) begin
                s = (r.key_hi[11:0] + i) % N_SLOTS;
                if (tbl_exp[s] != 0 && tbl_key[s] == k) begin
                    victim = s;
                    found = 1;
                    break;
                end
                if (tbl_exp[s] == 0 || lapsed(tbl_exp[s], r.now_ms)) begin
                    if (!got_empty) begin
                        empty_s = s;
                        got_empty = 1;
                    end
                    continue;
                end
                dd = tbl_exp[s] - tbl_exp[soon_s];
                if (!got_soon || dd[31]) begin
                    soon_s = s;
                    got_soon = 1;
                end
            end
            if (!found) victim = got_empty ? empty_s : soon_s;
            tbl_key[victim] = k;
            tbl_exp[victim] = r.now_ms + r.ttl_ms;
            n_inserts++;
        end
        v.hit_count = n_hits;
        v.miss_count = n_misses;
        v.insert_count = n_inserts;
        return v;
    endfunction

    task automatic write_enable(logic value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_ENABLE; pwdata <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cache_on = value;
    endtask

    task automatic send_beat(t_req r, logic known, t_verdict want);
        t_verdict v;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        req_q   <= r;
        v = predict_verdict(r);
        if (known && v !== want) begin
            $display("%0t table row: expected %h predicted %h", $time, want, v);
            errors++;
        end
        verdicts_due.push_back(v);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain(int extra);
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_hit) hits_seen++;
                if (verdicts_due.size() == 0) begin
                    $display("%0t unexpected beat: actual %h", $time,
                             {o_hit, o_hit_count, o_miss_count, o_insert_count});
                    errors++;
                end else begin
                    t_verdict e;
                    e = verdicts_due.pop_front();
                    if (o_hit !== e.hit)
                        $display("%0t hit: expected %0d actual %0d", $time, e.hit, o_hit);
                    if (o_hit_count !== e.hit_count)
                        $display("%0t hit_count: expected %0d actual %0d", $time,
                                 e.hit_count, o_hit_count);
                    if (o_miss_count !== e.miss_count)
                        $display("%0t miss_count: expected %0d actual %0d", $time,
                                 e.miss_count, o_miss_count);
                    if (o_insert_count !== e.insert_count)
                        $display("%0t insert_count: expected %0d actual %0d", $time,
                                 e.insert_count, o_insert_count);
                    if ({o_hit, o_hit_count, o_miss_count, o_insert_count} !== e)
                        errors++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_req mk(logic cmd, logic [63:0] khi, logic [63:0] klo,
                                logic [31:0] rt, logic [7:0] ph, logic [7:0] op,
                                logic [31:0] ttl, logic [31:0] now);
        return '{cmd, khi, klo, rt, ph, op, ttl, now};
    endfunction

    // random requests aimed at two crowded windows so hits and evictions happen
    logic [63:0] pool_hi [16];
    logic [63:0] pool_lo [16];
    logic [31:0] clock_ms;

    function automatic t_req random_req();
        t_req r;
        int   p;
        p = $urandom_range(15);
        clock_ms += $urandom_range(40);
        r.command = $urandom_range(1);
        if ($urandom_range(9) < 8) begin
            r.key_hi = pool_hi[p];
            r.key_lo = pool_lo[p];
            r.route  = p[1:0];
            r.phase  = 8'hA5;
            r.opcode = {7'd0, p[2]};
        end else begin
            r.key_hi = {$urandom, $urandom};
            r.key_lo = {$urandom, $urandom};
            r.route  = $urandom;
            r.phase  = $urandom;
            r.opcode = $urandom;
        end
        case ($urandom_range(9))
            0: r.ttl_ms = 0;
            1: r.ttl_ms = $urandom;
            default: r.ttl_ms = $urandom_range(400, 1);
        endcase
        r.now_ms = ($urandom_range(19) == 0) ? $urandom : clock_ms;
        return r;
    endfunction

    t_row rows[$];

    initial begin
        t_verdict none;
        errors = 0; results_seen = 0; hits_seen = 0;
        send_idle_pct = 8; recv_idle_pct = 81;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_valid = 0; i_stall = 0; req_q = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            tbl_exp[i] = 0;
            tbl_key[i] = '0;
        end
        n_hits = 0; n_misses = 0; n_inserts = 0; cache_on = 0;
        none = '0;
        clock_ms = 32'd1000;
        for (int i = 0; i < 16; i++) begin
            pool_hi[i] = {$urandom, 20'd0, (i < 8) ? 12'hFFC : 12'h010};
            pool_hi[i][11:0] = pool_hi[i][11:0] + i[2:0];
            pool_lo[i] = {$urandom, $urandom};
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled: lookup misses uncounted, insert ignored
        rows.push_back('{mk(CMD_LOOKUP, '1, '1, '1, 8'hFF, 8'hFF, '1, '1), 1, none});
        rows.push_back('{mk(CMD_INSERT, '1, '1, '1, 8'hFF, 8'hFF, '1, '1), 1, none});
        foreach (rows[i]) send_beat(rows[i].req, rows[i].known, rows[i].res);
        rows.delete();
        drain(40);
        write_enable(1'b1);

        rows.push_back('{mk(CMD_LOOKUP, 64'h0, 64'h0, 0, 0, 0, 0, 0), 1, '{0, 0, 1, 0}});
        rows.push_back('{mk(CMD_INSERT, 64'h0, 64'h0, 0, 0, 0, 0, 5), 1, '{0, 0, 1, 0}});
        rows.push_back('{mk(CMD_INSERT, 64'h0, 64'h0, 0, 0, 0, 100, 5), 1, '{0, 0, 1, 1}});
        rows.push_back('{mk(CMD_LOOKUP, 64'h0, 64'h0, 0, 0, 0, 0, 50), 1, '{1, 1, 1, 1}});
        rows.push_back('{mk(CMD_LOOKUP, 64'h0, 64'h0, 0, 0, 1, 0, 50), 1, '{0, 1, 2, 1}});
        // exactly at expiry counts as expired and clears the slot
        rows.push_back('{mk(CMD_LOOKUP, 64'h0, 64'h0, 0, 0, 0, 0, 105), 1, '{0, 1, 3, 1}});
        rows.push_back('{mk(CMD_LOOKUP, 64'h0, 64'h0, 0, 0, 0, 0, 6), 1, '{0, 1, 4, 1}});
        // expiry wrapping to zero leaves an empty slot
        rows.push_back('{mk(CMD_INSERT, '1, '1, '1, 8'hFF, 8'hFF, 32'h1, '1), 1,
                         '{0, 1, 4, 2}});
        rows.push_back('{mk(CMD_LOOKUP, '1, '1, '1, 8'hFF, 8'hFF, 0, 32'hFFFF_0000), 1,
                         '{0, 1, 5, 2}});
        // maximum ttl across the wrap point
        rows.push_back('{mk(CMD_INSERT, 64'hFFF, 1, 2, 3, 4, '1, 32'h7FFF_FFFF), 0, none});
        rows.push_back('{mk(CMD_LOOKUP, 64'hFFF, 1, 2, 3, 4, 0, 32'h8000_0000), 0, none});
        // fill a window at the table end so it wraps, then evict the soonest
        for (int i = 0; i < 9; i++)
            rows.push_back('{mk(CMD_INSERT, 64'hABC0_0000_0000_0FFA, i, 9, 1, 1,
                                200 - i * 10, 1000), 0, none});
        rows.push_back('{mk(CMD_LOOKUP, 64'hABC0_0000_0000_0FFA, 8, 9, 1, 1, 0, 1001),
                         0, none});
        rows.push_back('{mk(CMD_LOOKUP, 64'hABC0_0000_0000_0FFA, 7, 9, 1, 1, 0, 1001),
                         0, none});
        foreach (rows[i]) send_beat(rows[i].req, rows[i].known, rows[i].res);

        for (int n = 0; n < 450; n++) begin
            if (n == 150) begin
                send_idle_pct = 81; recv_idle_pct = 8;
            end else if (n == 300) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (n == 100 || n == 350) begin
                drain(40);
                write_enable(1'b0);
            end else if (n == 120 || n == 370) begin
                drain(40);
                write_enable(1'b1);
            end
            if (n == 200) drain(0);
            send_beat(random_req(), 0, none);
        end

        drain(40);
        $display("ran %0d results (%0d hits), enable toggled, stalls on both sides",
                 results_seen, hits_seen);
        if (errors == 0) begin
            $display("[ttl_verdict_hash_cache] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[ttl_verdict_hash_cache] ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/tvhc_pkg.sv
rtl/ttl_verdict_hash_cache.sv
bench/ttl_verdict_hash_cache_tb.sv
